@@ src/cklc_pkg.sv @@
// Shared types, widths and constants of the complex kernel correlation line.
// Used by cklc_ctrl, cklc_dp and complex_kernel_correlation_line_top.
package cklc_pkg;

  localparam int DEF_MAX_TAPS = 64;
  localparam int DEF_MAX_LINE = 4096;

  localparam int IDX_W   = 6;   // coefficient index / store address
  localparam int SAMP_W  = 16;  // Q1.15 sample and coefficient
  localparam int ACC_W   = 38;  // Q8.30 correlation sums
  localparam int ABS_W   = 38;  // magnitude of one sum
  localparam int SQ_W    = 78;  // sum of squares, two bits per root digit
  localparam int MAG_W   = 39;
  localparam int REM_W   = 42;
  localparam int POS_W   = 12;
  localparam int PH_W    = 16;
  localparam int Z_W     = 18;
  localparam int CRD_W   = 40;  // CORDIC x and y
  localparam int CRD_ITER = 14;
  localparam int RESULT_CAP = 64;
  localparam int TAPS_W  = 7;
  localparam int CFG_W   = 7;

  localparam logic [PH_W-1:0] PI_Q13      = 16'sd25736;
  localparam logic [PH_W-1:0] HALF_PI_Q13 = 16'sd12868;

  // configuration register indexes
  localparam logic REG_KERNEL_TAPS   = 1'b0;
  localparam logic REG_KERNEL_CENTRE = 1'b1;

  // input kinds carried on tuser
  localparam logic CMD_COEFF  = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef struct packed {
    logic             win_we;
    logic [IDX_W-1:0] win_addr;
    logic             coef_we;
    logic             rd_en;
    logic [IDX_W-1:0] rd_saddr;
    logic [IDX_W-1:0] rd_kaddr;
    logic             acc_clr;
    logic             sq_init;
    logic             sq_step;
    logic             cd_step;
    logic [3:0]       cd_iter;
    logic             rt_step;
    logic             out_load;
    logic [POS_W-1:0] out_pos;
    logic             run_last;
    logic             line_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } stat_t;

  // atan(2^-i) in Q3.13, rounded
  function automatic logic [12:0] atan_q13(input logic [3:0] i);
    logic [12:0] v;
    case (i)
      4'd0:  v = 13'd6434;
      4'd1:  v = 13'd3798;
      4'd2:  v = 13'd2007;
      4'd3:  v = 13'd1019;
      4'd4:  v = 13'd511;
      4'd5:  v = 13'd256;
      4'd6:  v = 13'd128;
      4'd7:  v = 13'd64;
      4'd8:  v = 13'd32;
      4'd9:  v = 13'd16;
      4'd10: v = 13'd8;
      4'd11: v = 13'd4;
      4'd12: v = 13'd2;
      4'd13: v = 13'd1;
      default: v = 13'd0;
    endcase
    return v;
  endfunction

endpackage

@@ src/cklc_ctrl.sv @@
// Sequencer of the correlation line: config registers, line counters, FSM.
// Depends on cklc_pkg; drives cklc_dp through cklc_pkg::cmd_t.
module cklc_ctrl #(
  parameter int MAX_TAPS = cklc_pkg::DEF_MAX_TAPS,
  parameter int MAX_LINE = cklc_pkg::DEF_MAX_LINE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [cklc_pkg::CFG_W-1:0] cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic                       s_tuser,
  input  logic                       s_tlast,
  input  logic [cklc_pkg::IDX_W-1:0] coeff_index,
  output cklc_pkg::cmd_t             cmd,
  input  cklc_pkg::stat_t            stat
);

  localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int NW = $clog2(MAX_LINE) + 1;
  localparam int EW = ((NW > 7) ? NW : 7) + 1;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_CHECK = 9'b000000010,
    ST_MAC   = 9'b000000100,
    ST_DRAIN = 9'b000001000,
    ST_INIT  = 9'b000010000,
    ST_SQ    = 9'b000100000,
    ST_RT    = 9'b001000000,
    ST_OUT   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t      state, state_next;
  logic [6:0]  kernel_taps;
  logic [5:0]  kernel_centre;
  logic [NW-1:0] n, nop;
  logic [TW-1:0] nmod, pmod, saddr, kaddr;
  logic [6:0]  count, tcnt;
  logic [5:0]  step;
  logic        flush;

  logic [6:0]  taps, kc, rext, left, right;
  logic        go_now, go_next;
  logic [EW-1:0] n_e, nop_e, nop1_e;
  logic [7:0]  s_start;
  logic        accept;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_taps   <= 7'd1;
      kernel_centre <= 6'd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cklc_pkg::REG_KERNEL_TAPS:   kernel_taps   <= cfg_data;
        cklc_pkg::REG_KERNEL_CENTRE: kernel_centre <= cfg_data[5:0];
        default: ;
      endcase
    end
  end

  // effective kernel geometry
  always_comb begin
    if (kernel_taps == 7'd0) taps = 7'd1;
    else if (kernel_taps > 7'(MAX_TAPS)) taps = 7'(MAX_TAPS);
    else taps = kernel_taps;
    kc   = ({1'b0, kernel_centre} < taps) ? {1'b0, kernel_centre} : taps - 7'd1;
    rext = taps - kc - 7'd1;
  end

  // is a position ready: current and the one after it
  always_comb begin
    n_e    = EW'(n);
    nop_e  = EW'(nop);
    nop1_e = nop_e + EW'(1);
    go_now  = (nop_e <= n_e) && (flush || (nop_e + EW'(rext) <= n_e)) &&
              (count < 7'(cklc_pkg::RESULT_CAP));
    go_next = (nop1_e <= n_e) && (flush || (nop1_e + EW'(rext) <= n_e)) &&
              ((count + 7'd1) < 7'(cklc_pkg::RESULT_CAP));
    left  = (nop_e < EW'(kc)) ? 7'(nop) : kc;
    right = ((n_e - nop_e) < EW'(rext)) ? 7'(n_e - nop_e) : rext;
    s_start = 8'(pmod) - 8'(left);
    if (8'(pmod) < 8'(left)) s_start = s_start + 8'(MAX_TAPS);
  end

  assign accept = s_tvalid && (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept && s_tuser == cklc_pkg::CMD_SAMPLE) state_next = ST_CHECK;
      ST_CHECK: state_next = go_now ? ST_MAC : ST_DONE;
      ST_MAC:   if (tcnt == 7'd0) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_INIT;
      ST_INIT:  state_next = ST_SQ;
      ST_SQ:    if (step == 6'(cklc_pkg::ABS_W - 1)) state_next = ST_RT;
      ST_RT:    if (step == 6'(cklc_pkg::MAG_W - 1)) state_next = ST_OUT;
      ST_OUT:   if (stat.out_free) state_next = ST_CHECK;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // counters and pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      n     <= '0;
      nop   <= '0;
      nmod  <= '0;
      pmod  <= '0;
      count <= '0;
      flush <= 1'b0;
      tcnt  <= '0;
      step  <= '0;
      saddr <= '0;
      kaddr <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept && s_tuser == cklc_pkg::CMD_SAMPLE) begin
            flush <= s_tlast || (n >= NW'(MAX_LINE - 1));
            count <= '0;
          end
        end
        ST_CHECK: begin
          tcnt  <= left + right;
          saddr <= TW'(s_start);
          kaddr <= TW'(kc - left);
        end
        ST_MAC: begin
          tcnt  <= tcnt - 7'd1;
          saddr <= (saddr == TW'(MAX_TAPS - 1)) ? '0 : saddr + TW'(1);
          kaddr <= kaddr + TW'(1);
        end
        ST_INIT: step <= '0;
        ST_SQ: step <= (step == 6'(cklc_pkg::ABS_W - 1)) ? 6'd0 : step + 6'd1;
        ST_RT: step <= step + 6'd1;
        ST_OUT: begin
          if (stat.out_free) begin
            nop   <= nop + NW'(1);
            pmod  <= (pmod == TW'(MAX_TAPS - 1)) ? '0 : pmod + TW'(1);
            count <= count + 7'd1;
          end
        end
        ST_DONE: begin
          if (flush && (nop > n)) begin
            n    <= '0;
            nop  <= '0;
            nmod <= '0;
            pmod <= '0;
          end else begin
            n    <= n + NW'(1);
            nmod <= (nmod == TW'(MAX_TAPS - 1)) ? '0 : nmod + TW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // commands to the datapath
  always_comb begin
    cmd = '0;
    cmd.win_addr = cklc_pkg::IDX_W'(nmod);
    cmd.rd_saddr = cklc_pkg::IDX_W'(saddr);
    cmd.rd_kaddr = cklc_pkg::IDX_W'(kaddr);
    cmd.cd_iter  = step[3:0];
    cmd.out_pos  = cklc_pkg::POS_W'(nop);
    cmd.run_last = !go_next;
    cmd.line_last = flush && (nop == n);
    s_tready = (state == ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        cmd.win_we  = accept && (s_tuser == cklc_pkg::CMD_SAMPLE);
        cmd.coef_we = accept && (s_tuser == cklc_pkg::CMD_COEFF) &&
                      ({1'b0, coeff_index} < 7'(MAX_TAPS));
      end
      ST_CHECK: cmd.acc_clr  = 1'b1;
      ST_MAC:   cmd.rd_en    = 1'b1;
      ST_INIT:  cmd.sq_init  = 1'b1;
      ST_SQ: begin
        cmd.sq_step = 1'b1;
        cmd.cd_step = (step < 6'(cklc_pkg::CRD_ITER));
      end
      ST_RT:    cmd.rt_step  = 1'b1;
      ST_OUT:   cmd.out_load = stat.out_free;
      default: ;
    endcase
  end

endmodule

@@ src/cklc_dp.sv @@
// Datapath: coefficient store, sample window, MAC, squaring, square root,
// CORDIC phase and the output register. Depends on cklc_pkg.
module cklc_dp #(
  parameter int MAX_TAPS = cklc_pkg::DEF_MAX_TAPS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cklc_pkg::cmd_t              cmd,
  output cklc_pkg::stat_t             stat,
  input  logic [cklc_pkg::IDX_W-1:0]  coeff_index,
  input  logic signed [cklc_pkg::SAMP_W-1:0] coeff_real,
  input  logic signed [cklc_pkg::SAMP_W-1:0] coeff_imag,
  input  logic signed [cklc_pkg::SAMP_W-1:0] sample_value,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [71:0]                 m_tdata,
  output logic [0:0]                  m_tuser,
  output logic                        m_tlast
);

  localparam int TW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int SW = cklc_pkg::SAMP_W;
  localparam int AW = cklc_pkg::ACC_W;
  localparam int CW = cklc_pkg::CRD_W;
  localparam int ZW = cklc_pkg::Z_W;

  // stores
  logic [2*SW-1:0] coef_mem [MAX_TAPS];
  logic [SW-1:0]   win_mem  [MAX_TAPS];
  logic [MAX_TAPS-1:0] win_valid;

  logic signed [SW-1:0] s_rd, kr_rd, ki_rd;
  logic                 s_vld, mac_en;

  always_ff @(posedge clk) begin
    if (cmd.coef_we) coef_mem[TW'(coeff_index)] <= {coeff_imag, coeff_real};
    if (cmd.win_we)  win_mem[TW'(cmd.win_addr)] <= sample_value;
    if (cmd.rd_en) begin
      s_rd  <= win_mem[TW'(cmd.rd_saddr)];
      {ki_rd, kr_rd} <= coef_mem[TW'(cmd.rd_kaddr)];
      s_vld <= win_valid[TW'(cmd.rd_saddr)];
    end
  end

  // window entries read as zero until first written
  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= '0;
      mac_en    <= 1'b0;
    end else begin
      if (cmd.win_we) win_valid[TW'(cmd.win_addr)] <= 1'b1;
      mac_en <= cmd.rd_en;
    end
  end

  // multiply-accumulate, conjugated kernel
  logic signed [AW-1:0] acc_re, acc_im;
  logic signed [SW-1:0] s_use;
  logic signed [2*SW-1:0] p_re, p_im;

  always_comb begin
    s_use = s_vld ? s_rd : '0;
    p_re  = s_use * kr_rd;
    p_im  = s_use * ki_rd;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_re <= '0;
      acc_im <= '0;
    end else if (mac_en) begin
      acc_re <= acc_re + AW'(p_re);
      acc_im <= acc_im - AW'(p_im);
    end
  end

  // sum of squares by shift-and-add, then digit-by-digit square root
  logic [cklc_pkg::ABS_W-1:0] ar_sh, ai_sh;
  logic [cklc_pkg::SQ_W-1:0]  ash, bsh, nsum;
  logic [cklc_pkg::MAG_W-1:0] root;
  logic [cklc_pkg::REM_W-1:0] rem, rem_sh, trial;

  always_comb begin
    rem_sh = {rem[cklc_pkg::REM_W-3:0], nsum[cklc_pkg::SQ_W-1 -: 2]};
    trial  = cklc_pkg::REM_W'({root, 2'b01});
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      ar_sh <= cklc_pkg::ABS_W'(acc_re[AW-1] ? -acc_re : acc_re);
      ai_sh <= cklc_pkg::ABS_W'(acc_im[AW-1] ? -acc_im : acc_im);
      ash   <= cklc_pkg::SQ_W'(acc_re[AW-1] ? -acc_re : acc_re);
      bsh   <= cklc_pkg::SQ_W'(acc_im[AW-1] ? -acc_im : acc_im);
      nsum  <= '0;
      rem   <= '0;
      root  <= '0;
    end else if (cmd.sq_step) begin
      nsum  <= nsum + (ar_sh[0] ? ash : '0) + (ai_sh[0] ? bsh : '0);
      ar_sh <= ar_sh >> 1;
      ai_sh <= ai_sh >> 1;
      ash   <= ash << 1;
      bsh   <= bsh << 1;
    end else if (cmd.rt_step) begin
      nsum <= nsum << 2;
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[cklc_pkg::MAG_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[cklc_pkg::MAG_W-2:0], 1'b0};
      end
    end
  end

  // CORDIC vectoring for the phase
  logic signed [CW-1:0] cx, cy, xs, ys;
  logic signed [ZW-1:0] cz, base, zsum;
  logic                 spec;
  logic signed [cklc_pkg::PH_W-1:0] spec_val, phase;
  logic signed [CW-1:0] x0, y0;
  logic signed [ZW-1:0] at;

  always_comb begin
    x0 = CW'(acc_re);
    y0 = CW'(acc_im);
    xs = cx >>> cmd.cd_iter;
    ys = cy >>> cmd.cd_iter;
    at = ZW'(cklc_pkg::atan_q13(cmd.cd_iter));
    zsum = base + cz;
    if (spec) phase = spec_val;
    else if (zsum > ZW'(signed'(cklc_pkg::PI_Q13))) phase = cklc_pkg::PI_Q13;
    else if (zsum < -ZW'(signed'(cklc_pkg::PI_Q13))) phase = -cklc_pkg::PI_Q13;
    else phase = cklc_pkg::PH_W'(zsum);
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_init) begin
      cz <= '0;
      spec <= (y0 == '0) || (x0 == '0);
      if (y0 == '0) spec_val <= (x0 < 0) ? cklc_pkg::PI_Q13 : '0;
      else spec_val <= (y0 > 0) ? cklc_pkg::HALF_PI_Q13 : -cklc_pkg::HALF_PI_Q13;
      if (x0 < 0) begin
        base <= (y0 > 0) ? ZW'(signed'(cklc_pkg::PI_Q13)) : -ZW'(signed'(cklc_pkg::PI_Q13));
        cx   <= -x0;
        cy   <= -y0;
      end else begin
        base <= '0;
        cx   <= x0;
        cy   <= y0;
      end
    end else if (cmd.cd_step) begin
      if (cy > 0) begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + at;
      end else begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - at;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (cmd.out_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= {5'd0, phase, root, cmd.out_pos};
      m_tuser <= cmd.run_last;
      m_tlast <= cmd.line_last;
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

endmodule

@@ src/complex_kernel_correlation_line_top.sv @@
// Top level of the complex kernel correlation line: magnitude and phase.
// Depends on cklc_pkg, cklc_ctrl and cklc_dp.
//
// channel   direction  fields
// s_*       in         tdata: coeff_index, coeff_real, coeff_imag, sample_value
//                      tuser: command; tlast: line_end
// m_*       out        tdata: position, magnitude, phase
//                      tuser: run_last; tlast: line_last
// cfg_*     in         register write: kernel_taps (0), kernel_centre (1)
//
// A coefficient beat only writes the coefficient store. A sample beat is stored,
// then, for each position it releases: one MAC per tap used, then a shift-add
// squaring (with the 14 CORDIC steps alongside) and a root, one bit a cycle.
// Reset clears the window to zero at once.
// A stalled output holds the sequencer at the load of the next result.
module complex_kernel_correlation_line_top #(
  parameter int MAX_TAPS = cklc_pkg::DEF_MAX_TAPS,
  parameter int MAX_LINE = cklc_pkg::DEF_MAX_LINE
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,  // coeff_index, coeff_real, coeff_imag, sample_value
  input  logic [0:0]  s_tuser,  // command
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,  // position, magnitude, phase
  output logic [0:0]  m_tuser,  // run_last
  output logic        m_tlast
);

  cklc_pkg::cmd_t  cmd;
  cklc_pkg::stat_t stat;

  cklc_ctrl #(.MAX_TAPS(MAX_TAPS), .MAX_LINE(MAX_LINE)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tuser     (s_tuser[0]),
    .s_tlast     (s_tlast),
    .coeff_index (s_tdata[5:0]),
    .cmd         (cmd),
    .stat        (stat)
  );

  cklc_dp #(.MAX_TAPS(MAX_TAPS)) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .coeff_index  (s_tdata[5:0]),
    .coeff_real   (s_tdata[21:6]),
    .coeff_imag   (s_tdata[37:22]),
    .sample_value (s_tdata[53:38]),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

  // the final position of a line always closes its run
  a_line_closes_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser[0])
    else $error("line_last without run_last");

  // a sample beat starts a sequence, so input stalls next cycle
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] |=> !s_tready)
    else $error("input ready right after a sample");

  // nothing is offered straight out of reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

@@ tb/sv/complex_kernel_correlation_line_checker.sv @@
// Checker for the complex kernel correlation line: watches the config, input and
// output channels, predicts magnitude/phase per line position and compares.
// Depends on cklc_pkg for register indexes and input kinds.
module complex_kernel_correlation_line_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [55:0] s_tdata,
  input  logic [0:0]  s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [71:0] m_tdata,
  input  logic [0:0]  m_tuser,
  input  logic        m_tlast,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [11:0] pos;
    logic [38:0] mag;
    logic [15:0] ph;
    logic        run_last;
    logic        line_last;
  } corr_result_t;

  corr_result_t    expected_q[$];
  logic [6:0]      taps_reg;
  logic [5:0]      centre_reg;
  logic signed [15:0] k_re [64];
  logic signed [15:0] k_im [64];
  logic signed [15:0] window [64];
  int unsigned     line_count;
  int unsigned     next_pos;

  const int angle_step [14] = '{6434, 3798, 2007, 1019, 511, 256, 128, 64, 32, 16,
                                8, 4, 2, 1};

  assign pending = expected_q.size();

  // exact floor square root of re^2 + im^2
  function automatic logic [38:0] isqrt_mag(longint re, longint im);
    logic [79:0] ar, ai, n, c;
    logic [38:0] m;
    ar = (re < 0) ? -re : re;
    ai = (im < 0) ? -im : im;
    n = ar * ar + ai * ai;
    m = '0;
    for (int b = 38; b >= 0; b--) begin
      c = {41'd0, m | (39'd1 << b)};
      if (c * c <= n) m = c[38:0];
    end
    return m;
  endfunction

  // vectoring CORDIC atan2, Q3.13
  function automatic logic [15:0] atan2_q13(longint x, longint y);
    longint z, base, xs, ys;
    z = 0;
    base = 0;
    if (y == 0) return (x < 0) ? 16'sd25736 : 16'sd0;
    if (x == 0) return (y > 0) ? 16'sd12868 : -16'sd12868;
    if (x < 0) begin
      base = (y > 0) ? 25736 : -25736;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 14; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z += angle_step[i];
      end else begin
        x = x - ys; y = y + xs; z -= angle_step[i];
      end
    end
    z += base;
    if (z > 25736) z = 25736;
    if (z < -25736) z = -25736;
    return z[15:0];
  endfunction

  // one sample beat: store it and queue every position it releases
  task automatic correlate_sample(logic signed [15:0] smp, logic last);
    int unsigned taps, kc, rext, n, p, left, right, cnt;
    longint re, im, s;
    logic flush;
    corr_result_t r;
    taps = (taps_reg == 0) ? 1 : ((taps_reg > 64) ? 64 : taps_reg);
    kc = (centre_reg < taps) ? centre_reg : taps - 1;
    rext = taps - kc - 1;
    n = line_count;
    window[n % 64] = smp;
    flush = last || (n >= 4095);
    cnt = 0;
    while (cnt < 64 && next_pos <= n && (flush || next_pos + rext <= n)) begin
      p = next_pos;
      left = (p < kc) ? p : kc;
      right = ((n - p) < rext) ? (n - p) : rext;
      re = 0;
      im = 0;
      for (int unsigned t = 0; t <= left + right; t++) begin
        s = window[(p - left + t) % 64];
        re += s * k_re[kc - left + t];
        im -= s * k_im[kc - left + t];
      end
      r.pos = p[11:0];
      r.mag = isqrt_mag(re, im);
      r.ph = atan2_q13(re, im);
      r.run_last = 1'b0;
      r.line_last = flush && (p == n);
      expected_q.push_back(r);
      next_pos = p + 1;
      cnt++;
    end
    if (cnt > 0) expected_q[$].run_last = 1'b1;
    if (flush && next_pos > n) begin
      line_count = 0;
      next_pos = 0;
    end else begin
      line_count = n + 1;
    end
  endtask

  always @(posedge clk) begin
    corr_result_t e;
    if (rst) begin
      taps_reg <= 7'd1;
      centre_reg <= 6'd0;
      for (int i = 0; i < 64; i++) begin
        window[i] = '0;
        k_re[i] = '0;
        k_im[i] = '0;
      end
      line_count = 0;
      next_pos = 0;
      expected_q.delete();
      fail_count <= 0;
    end else begin
      // result beat against oldest expectation
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result beat tdata=%h", $time, m_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (m_tdata[11:0] !== e.pos || m_tdata[50:12] !== e.mag ||
              m_tdata[66:51] !== e.ph || m_tuser[0] !== e.run_last ||
              m_tlast !== e.line_last) begin
            $display("%0t: mismatch exp pos=%0d mag=%0d ph=%0d rl=%b ll=%b",
                     $time, e.pos, e.mag, $signed(e.ph), e.run_last, e.line_last);
            $display("%0t:          got pos=%0d mag=%0d ph=%0d rl=%b ll=%b",
                     $time, m_tdata[11:0], m_tdata[50:12], $signed(m_tdata[66:51]),
                     m_tuser[0], m_tlast);
            fail_count <= fail_count + 1;
          end
        end
      end
      // input beat
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == cklc_pkg::CMD_COEFF) begin
          k_re[s_tdata[5:0]] = s_tdata[21:6];
          k_im[s_tdata[5:0]] = s_tdata[37:22];
        end else begin
          correlate_sample(s_tdata[53:38], s_tlast);
        end
      end
      if (cfg_we) begin
        if (cfg_index == cklc_pkg::REG_KERNEL_TAPS) taps_reg <= cfg_data;
        else centre_reg <= cfg_data[5:0];
      end
    end
  end

endmodule

@@ tb/sv/complex_kernel_correlation_line_top_tb.sv @@
// Testbench top for the complex kernel correlation line: clock, reset, stimulus
// and verdict. Depends on cklc_pkg, the block and complex_kernel_correlation_line_checker.
module complex_kernel_correlation_line_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [6:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;  // coeff_index, coeff_real, coeff_imag, sample_value
  logic [0:0]  s_tuser = '0;  // command
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;       // position, magnitude, phase
  logic [0:0]  m_tuser;       // run_last
  logic        m_tlast;
  int          fail_count;
  int          pending;
  logic        no_idle = 1'b0;
  logic        loaded [64];
  int          taps_now = 1;
  int          beats_sent = 0;
  int          stall_cycles = 0;
  int          out_gap = 0;

  always #5 clk = ~clk;

  complex_kernel_correlation_line_top u_top (.*);

  complex_kernel_correlation_line_checker u_chk (.*);

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 20);
  endfunction

  // receiver back-pressure: ready stretches broken by gaps of random length
  always @(negedge clk) begin
    int g;
    if (out_gap > 0) begin
      m_tready <= 1'b0;
      out_gap <= out_gap - 1;
    end else begin
      g = gap_len();
      if (g == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        out_gap <= g - 1;
      end
    end
  end

  // stall watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("[complex_kernel_correlation_line_top] ERROR");
      $finish;
    end
  end

  task automatic send_beat(logic cmd, logic [5:0] idx, logic [15:0] cre,
                           logic [15:0] cim, logic [15:0] smp, logic last);
    int g;
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {2'b00, smp, cim, cre, idx};
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    beats_sent++;
    g = gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic load_coeff(logic [5:0] idx, logic [15:0] cre, logic [15:0] cim);
    send_beat(cklc_pkg::CMD_COEFF, idx, cre, cim, 16'($urandom), 1'($urandom));
    loaded[idx] = 1'b1;
  endtask

  task automatic send_sample(logic [15:0] smp, logic last);
    send_beat(cklc_pkg::CMD_SAMPLE, 6'($urandom), 16'($urandom), 16'($urandom),
              smp, last);
  endtask

  function automatic logic [15:0] rand_word();
    case ($urandom_range(5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(7) - 3);
      default: return 16'($urandom);
    endcase
  endfunction

  // wait for the block to drain, then let a result in flight finish
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [6:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == cklc_pkg::REG_KERNEL_TAPS)
      taps_now = (val == 0) ? 1 : ((val > 64) ? 64 : val);
  endtask

  // configure, then fill any coefficient that the new length could read
  task automatic set_kernel(logic [6:0] taps, logic [6:0] centre);
    drain();
    write_reg(cklc_pkg::REG_KERNEL_TAPS, taps);
    write_reg(cklc_pkg::REG_KERNEL_CENTRE, centre);
    for (int i = 0; i < taps_now; i++)
      if (!loaded[i]) load_coeff(6'(i), rand_word(), rand_word());
  endtask

  initial begin
    int len;
    for (int i = 0; i < 64; i++) loaded[i] = 1'b0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: single tap, extremes and phase special cases
    write_reg(cklc_pkg::REG_KERNEL_TAPS, 7'd1);
    write_reg(cklc_pkg::REG_KERNEL_CENTRE, 7'd0);
    load_coeff(6'd0, 16'h7FFF, 16'h8000);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'h0001, 1'b1);
    load_coeff(6'd0, 16'h4000, 16'h0000);   // real kernel: phase 0 or pi
    send_sample(16'hFFFF, 1'b0);
    send_sample(16'h1234, 1'b1);
    load_coeff(6'd0, 16'h0000, 16'h8000);   // imaginary kernel: +-pi/2
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    load_coeff(6'd63, 16'h5555, 16'hAAAA);
    load_coeff(6'd0, 16'h8000, 16'h7FFF);
    send_sample(16'hAAAA, 1'b1);

    // taps and centre out of range, then the widest kernel
    set_kernel(7'd0, 7'd63);
    send_sample(16'h5555, 1'b0);
    send_sample(16'h8000, 1'b1);
    set_kernel(7'd127, 7'd63);
    for (int i = 0; i < 6; i++) send_sample(rand_word(), i == 5);

    // result cap: hold 63 positions back, then release all at once
    set_kernel(7'd64, 7'd0);
    for (int i = 0; i < 63; i++) send_sample(rand_word(), 1'b0);
    set_kernel(7'd1, 7'd0);
    send_sample(rand_word(), 1'b0);
    send_sample(rand_word(), 1'b1);

    // random phases
    while (beats_sent < 470) begin
      case ($urandom_range(3))
        0: set_kernel(7'($urandom_range(4, 1)), 7'($urandom_range(3)));
        1: set_kernel(7'($urandom_range(16, 1)), 7'($urandom_range(15)));
        2: set_kernel(7'($urandom_range(64, 1)), 7'($urandom_range(63)));
        default: set_kernel(7'($urandom_range(127)), 7'($urandom_range(127)));
      endcase
      no_idle = ($urandom_range(3) == 0);
      for (int l = 0; l < 3; l++) begin
        len = $urandom_range(30, 1);
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0)
            load_coeff(6'($urandom_range(taps_now - 1)), rand_word(), rand_word());
          if ($urandom_range(19) == 0)
            load_coeff(6'($urandom), rand_word(), rand_word());
          send_sample(rand_word(), i == len - 1);
        end
      end
      no_idle = 1'b0;
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (fail_count == 0)
      $display("[complex_kernel_correlation_line_top] OK");
    else
      $display("[complex_kernel_correlation_line_top] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
src/cklc_pkg.sv
src/cklc_ctrl.sv
src/cklc_dp.sv
src/complex_kernel_correlation_line_top.sv
tb/sv/complex_kernel_correlation_line_checker.sv
tb/sv/complex_kernel_correlation_line_top_tb.sv
